>>> sv/fpd_pkg.sv
// Shared types and constants for the fixed-point divider.
`timescale 1ns / 1ps
package fpd_pkg;

  localparam int WORD_W          = 32;
  localparam int FRAC_BITS       = 16;
  // Restoring steps: the whole dividend, then the fraction steps.
  localparam int NUM_W           = WORD_W + FRAC_BITS;
  localparam int STEPS_PER_STAGE = 4;
  localparam int NUM_STAGES      = (NUM_W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  // Numerator width rounded up to whole stages; leading zero steps change nothing.
  localparam int PAD_W           = NUM_STAGES * STEPS_PER_STAGE;
  localparam int IN_DATA_W       = 2 * WORD_W;

  typedef logic [WORD_W-1:0] word_t;

  // Divider state carried down the pipeline.
  typedef struct packed {
    word_t             rem;
    logic [PAD_W-1:0]  num;
    word_t             quo;
    word_t             den;
    logic              neg;
    logic              dbz;
  } div_state_t;

  // One result item.
  typedef struct packed {
    word_t quo;
    logic  dbz;
  } out_item_t;

endpackage

>>> sv/fixed_point_divider_unit.sv
// Signed Q16.16 divider, fully pipelined. One dividend/divisor pair is taken
// per cycle and each gives exactly one item. The quotient is the low 32 bits
// of (|dividend| << 16) / |divisor| with the sign applied afterwards, so the
// integer part wraps; the most negative operand counts as magnitude 2^31. A
// zero divisor returns quotient zero with out_tuser set. From accept to
// out_tvalid an item passes one operand register, the 48 restoring steps
// at four per stage over twelve stages, one sign stage and the output
// register. Throughput is one item per clock; when the consumer stalls, the
// pipeline freezes once the skid entry behind the output register is full,
// and in_tready is a register output.
`timescale 1ns / 1ps
module fixed_point_divider_unit
  import fpd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,   // [31:0] dividend, [63:32] divisor
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [WORD_W-1:0]    out_tdata,  // [31:0] quotient
  output logic [0:0]           out_tuser   // [0] divide_by_zero
);

  // Whole pipeline moves together; it holds only while the skid entry is full.
  logic       adv;
  logic       prep_valid;
  div_state_t prep_state;
  logic       stg_valid [NUM_STAGES+1];
  div_state_t stg_state [NUM_STAGES+1];
  logic       post_valid;
  out_item_t  post_item;
  out_item_t  out_item;

  assign in_tready = adv;

  fpd_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_tvalid),
    .in_data  (in_tdata),
    .valid_r  (prep_valid),
    .state_r  (prep_state)
  );

  assign stg_valid[0] = prep_valid;
  assign stg_state[0] = prep_state;

  // Restoring division, STEPS_PER_STAGE steps per register stage.
  for (genvar s = 0; s < NUM_STAGES; s++) begin : g_div
    fpd_div_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .in_valid (stg_valid[s]),
      .in_state (stg_state[s]),
      .valid_r  (stg_valid[s+1]),
      .state_r  (stg_state[s+1])
    );
  end

  fpd_post u_post (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (stg_valid[NUM_STAGES]),
    .in_state (stg_state[NUM_STAGES]),
    .valid_r  (post_valid),
    .item_r   (post_item)
  );

  fpd_skid u_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (post_valid),
    .push_item  (post_item),
    .push_ready (adv),
    .pop_valid  (out_tvalid),
    .pop_item   (out_item),
    .pop_ready  (out_tready)
  );

  assign out_tdata    = out_item.quo;
  assign out_tuser[0] = out_item.dbz;

`ifndef SYNTH
  // Input is only held off while a result waits at the output.
  a_stall_has_output: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no result pending");

  // Zero divisor always comes out as quotient zero.
  a_dbz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0)
    else $error("divide by zero gave nonzero quotient");

  // A zero divisor accepted is flagged in the operand stage next cycle.
  a_dbz_prep: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tdata[IN_DATA_W-1:WORD_W] == '0)
    |=> prep_valid && prep_state.dbz)
    else $error("zero divisor not flagged");
`endif

endmodule

>>> sv/fpd_prep.sv
// Operand stage: magnitudes, result sign and zero-divisor check.
`timescale 1ns / 1ps
module fpd_prep
  import fpd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 in_valid,
  input  logic [IN_DATA_W-1:0] in_data,
  output logic                 valid_r,
  output div_state_t           state_r
);

  word_t      a;
  word_t      b;
  word_t      mag_a;
  word_t      mag_b;
  div_state_t state_nxt;

  assign a = in_data[WORD_W-1:0];
  assign b = in_data[IN_DATA_W-1:WORD_W];

  // Most negative value maps to 2^31, which fits unsigned.
  assign mag_a = a[WORD_W-1] ? (word_t'(0) - a) : a;
  assign mag_b = b[WORD_W-1] ? (word_t'(0) - b) : b;

  always_comb begin
    state_nxt     = '0;
    state_nxt.num = PAD_W'(mag_a) << FRAC_BITS;
    state_nxt.den = mag_b;
    state_nxt.neg = a[WORD_W-1] ^ b[WORD_W-1];
    state_nxt.dbz = (b == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> sv/fpd_div_stage.sv
// One pipeline stage of restoring division: a fixed group of steps.
`timescale 1ns / 1ps
module fpd_div_stage
  import fpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       adv,
  input  logic       in_valid,
  input  div_state_t in_state,
  output logic       valid_r,
  output div_state_t state_r
);

  div_state_t state_nxt;

  always_comb begin
    logic [WORD_W:0]  trial;
    word_t            rem_v;
    logic [PAD_W-1:0] num_v;
    word_t            quo_v;
    state_nxt = in_state;
    rem_v     = in_state.rem;
    num_v     = in_state.num;
    quo_v     = in_state.quo;
    for (int i = 0; i < STEPS_PER_STAGE; i++) begin
      trial = {rem_v, num_v[PAD_W-1]};
      num_v = num_v << 1;
      if (trial >= {1'b0, in_state.den}) begin
        trial = trial - {1'b0, in_state.den};
        quo_v = {quo_v[WORD_W-2:0], 1'b1};
      end else begin
        quo_v = {quo_v[WORD_W-2:0], 1'b0};
      end
      // Remainder stays below the divisor, so the top bit drops out.
      rem_v = trial[WORD_W-1:0];
    end
    state_nxt.rem = rem_v;
    state_nxt.num = num_v;
    state_nxt.quo = quo_v;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> sv/fpd_post.sv
// Result stage: applies the sign and forces zero on a zero divisor.
`timescale 1ns / 1ps
module fpd_post
  import fpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       adv,
  input  logic       in_valid,
  input  div_state_t in_state,
  output logic       valid_r,
  output out_item_t  item_r
);

  out_item_t item_nxt;

  always_comb begin
    item_nxt.dbz = in_state.dbz;
    if (in_state.dbz) begin
      item_nxt.quo = '0;
    end else if (in_state.neg) begin
      item_nxt.quo = word_t'(0) - in_state.quo;
    end else begin
      item_nxt.quo = in_state.quo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item_r <= item_nxt;
    end
  end

endmodule

>>> sv/fpd_skid.sv
// Output register with a skid entry; its ready is a register.
`timescale 1ns / 1ps
module fpd_skid
  import fpd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  input  out_item_t push_item,
  output logic      push_ready,
  output logic      pop_valid,
  output out_item_t pop_item,
  input  logic      pop_ready
);

  logic      main_valid_r;
  logic      main_valid_nxt;
  out_item_t main_r;
  out_item_t main_nxt;
  logic      skid_valid_r;
  logic      skid_valid_nxt;
  out_item_t skid_r;
  out_item_t skid_nxt;
  logic      take;
  logic      push;

  assign take       = main_valid_r && pop_ready;
  assign push       = push_valid && !skid_valid_r;
  assign push_ready = !skid_valid_r;
  assign pop_valid  = main_valid_r;
  assign pop_item   = main_r;

  always_comb begin
    main_valid_nxt = main_valid_r;
    main_nxt       = main_r;
    skid_valid_nxt = skid_valid_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      if (take) begin
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_valid_r || take) begin
        main_nxt       = push_item;
        main_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = push_item;
        skid_valid_nxt = 1'b1;
      end
    end else if (take) begin
      main_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule

>>> test/fixed_point_divider_checker.sv
// Watches both channels of the divider, predicts each quotient and compares it.
`timescale 1ns / 1ps
module fixed_point_divider_checker
  import fpd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [WORD_W-1:0]    out_tdata,
  input  logic [0:0]           out_tuser,
  output int                   fail_count,
  output int                   quotients_pending,
  output int                   quotients_checked,
  output int                   zero_divisors_seen
);

  out_item_t expected_quotients[$];
  out_item_t oldest;

  initial begin
    fail_count         = 0;
    quotients_pending  = 0;
    quotients_checked  = 0;
    zero_divisors_seen = 0;
  end

  // Magnitudes are divided, the sign applied after; integer part wraps.
  function automatic out_item_t divide_q16(word_t dividend, word_t divisor);
    out_item_t   r;
    logic [63:0] mag_a;
    logic [63:0] mag_b;
    logic [63:0] q_full;
    word_t       mag_q;
    logic        flip;
    flip  = dividend[WORD_W-1] ^ divisor[WORD_W-1];
    mag_a = {32'b0, (dividend[WORD_W-1] ? word_t'(word_t'(0) - dividend) : dividend)};
    mag_b = {32'b0, (divisor[WORD_W-1] ? word_t'(word_t'(0) - divisor) : divisor)};
    if (divisor == '0) begin
      r.quo = '0;
      r.dbz = 1'b1;
    end else begin
      q_full = (mag_a << FRAC_BITS) / mag_b;
      mag_q  = q_full[WORD_W-1:0];
      r.quo  = flip ? word_t'(word_t'(0) - mag_q) : mag_q;
      r.dbz  = 1'b0;
    end
    return r;
  endfunction

  // One line per mismatch.
  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      // Result side first: an item accepted at this edge cannot leave at it.
      if (out_tvalid && out_tready) begin
        if (expected_quotients.size() == 0) begin
          report_mismatch($sformatf("unexpected item quotient=%h dbz=%0b",
                                    out_tdata, out_tuser[0]));
        end else begin
          oldest = expected_quotients.pop_front();
          if (out_tdata !== oldest.quo)
            report_mismatch($sformatf("quotient got %h want %h", out_tdata, oldest.quo));
          if (out_tuser[0] !== oldest.dbz)
            report_mismatch($sformatf("divide_by_zero got %b want %b",
                                      out_tuser[0], oldest.dbz));
          quotients_checked++;
        end
      end
      if (in_tvalid && in_tready) begin
        expected_quotients.push_back(divide_q16(in_tdata[WORD_W-1:0],
                                                in_tdata[2*WORD_W-1:WORD_W]));
        if (in_tdata[2*WORD_W-1:WORD_W] == '0) zero_divisors_seen++;
      end
      quotients_pending = expected_quotients.size();
    end
  end

endmodule

>>> test/fixed_point_divider_unit_tb.sv
// Top of the divider testbench: clock, reset, stimulus, output pacing and verdict.
`timescale 1ns / 1ps
module fixed_point_divider_unit_tb;
  import fpd_pkg::*;

  localparam int RANDOM_ITEMS = 1600;
  localparam int IDLE_LIMIT   = 5000;  // cycles with no item moving on either side
  localparam int HOLD_AT      = 300;   // results taken before the long output stall
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 30;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [IN_DATA_W-1:0] in_tdata   = '0;  // [31:0] dividend, [63:32] divisor
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [WORD_W-1:0]    out_tdata;        // [31:0] quotient
  logic [0:0]           out_tuser;        // [0] divide_by_zero

  int fail_count;
  int quotients_pending;
  int quotients_checked;
  int zero_divisors_seen;
  int pairs_sent    = 0;
  int results_taken = 0;
  int idle_cycles   = 0;
  int directed_pairs;

  fixed_point_divider_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  fixed_point_divider_checker checker_i (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_tvalid          (in_tvalid),
    .in_tready          (in_tready),
    .in_tdata           (in_tdata),
    .out_tvalid         (out_tvalid),
    .out_tready         (out_tready),
    .out_tdata          (out_tdata),
    .out_tuser          (out_tuser),
    .fail_count         (fail_count),
    .quotients_pending  (quotients_pending),
    .quotients_checked  (quotients_checked),
    .zero_divisors_seen (zero_divisors_seen)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog: counts cycles in which no item is accepted on either channel.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles + 1 >= IDLE_LIMIT) begin
          $display("timeout: nothing accepted for %0d cycles", IDLE_LIMIT);
          $display("RESULT: ERROR");
          $finish;
        end
      end
    end
  end

  // Offer one operand pair; returns at the edge where it is accepted.
  // Every fourth stretch of 25 pairs goes without gaps.
  task automatic offer_pair(input word_t dividend, input word_t divisor);
    int gap;
    gap = ((pairs_sent % 100) < 25) ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {divisor, dividend};
    do @(posedge clk); while (!in_tready);
    pairs_sent++;
  endtask

  // Random operand: corners, full-range words, small Q16 values, pure fractions,
  // and shifted words so that every magnitude order appears.
  function automatic word_t rand_operand();
    word_t v;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 5))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = 32'h0000_0001;
          3: v = 32'hFFFF_FFFF;
          4: v = 32'h0001_0000;
          default: v = 32'hFFFF_0000;
        endcase
      end
      1, 2: v = $urandom;
      3, 4: v = $urandom & 32'h000F_FFFF;
      5: v = $urandom_range(0, 65535);
      default: v = $urandom >> $urandom_range(0, 31);
    endcase
    if (v != 32'h8000_0000 && v != 32'h7FFF_FFFF && $urandom_range(0, 1))
      v = word_t'(0) - v;
    return v;
  endfunction

  // Receiver: random pause per item, no pauses in some stretches, and one
  // long hold-off so the pipeline fills and in_tready drops.
  initial begin
    int hold;
    while (!rst_n) @(posedge clk);
    forever begin
      if (results_taken == HOLD_AT) hold = HOLD_CYCLES;
      else if ((results_taken % 128) < 32) hold = 0;
      else hold = $urandom_range(0, 9);
      if (hold > 0) begin
        out_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      results_taken++;
    end
  end

  initial begin
    word_t a;
    word_t b;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: plain values, signs, zero divisor, most negative operand,
    // integer wrap, and a zero quotient with differing signs.
    offer_pair(32'h0000_0000, 32'h0001_0000);
    offer_pair(32'h0001_0000, 32'h0001_0000);
    offer_pair(32'h0005_0000, 32'h0002_0000);
    offer_pair(word_t'(0) - 32'h0007_0000, 32'h0002_0000);
    offer_pair(32'h0007_0000, word_t'(0) - 32'h0002_0000);
    offer_pair(word_t'(0) - 32'h0003_0000, word_t'(0) - 32'h0004_0000);
    offer_pair(32'h0001_0000, 32'h0003_0000);
    offer_pair(32'h0001_2345, 32'h0000_0000);
    offer_pair(32'h0000_0000, 32'h0000_0000);
    offer_pair(32'h8000_0000, 32'h0000_0000);
    offer_pair(32'h7FFF_FFFF, 32'h0000_0000);
    offer_pair(32'h8000_0000, 32'h8000_0000);
    offer_pair(32'h8000_0000, 32'hFFFF_FFFF);
    offer_pair(32'h8000_0000, 32'h0001_0000);
    offer_pair(32'h8000_0000, 32'hFFFF_0000);
    offer_pair(32'h7FFF_FFFF, 32'h0000_0001);
    offer_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    offer_pair(32'h7FFF_FFFF, 32'h8000_0000);
    offer_pair(32'h0000_0001, 32'h7FFF_FFFF);
    offer_pair(32'hFFFF_FFFF, 32'h7FFF_FFFF);
    offer_pair(32'h0000_0001, 32'h8000_0000);
    offer_pair(32'h1234_5678, 32'hEDCB_A988);
    offer_pair(32'h0000_0000, 32'hFFFF_FFFF);
    directed_pairs = pairs_sent;

    repeat (RANDOM_ITEMS) begin
      a = rand_operand();
      b = ($urandom_range(0, 31) == 0) ? word_t'(0) : rand_operand();
      offer_pair(a, b);
    end
    in_tvalid <= 1'b0;

    while (quotients_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d operand pairs (%0d directed, rest random), checked %0d quotients,",
             pairs_sent, directed_pairs, quotients_checked);
    $display("%0d with zero divisor; random gaps on both sides plus one %0d-cycle output stall.",
             zero_divisors_seen, HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> fixed_point_divider_unit.f
sv/fpd_pkg.sv
sv/fpd_prep.sv
sv/fpd_div_stage.sv
sv/fpd_post.sv
sv/fpd_skid.sv
sv/fixed_point_divider_unit.sv
test/fixed_point_divider_checker.sv
test/fixed_point_divider_unit_tb.sv
